// File: rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SH_W   = SLOT_W + 1;
    localparam int POS_W  = 16;
    localparam int KIND_W = 4;
    localparam int STAT_W = 2;
    localparam int STEP_CNT_W = $clog2(POS_W);

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 48;

    localparam int OUT_DATA_LSB = 0;
    localparam int OUT_STAT_LSB = OUT_DATA_LSB + DATA_W;
    localparam int OUT_OCC_LSB  = OUT_STAT_LSB + STAT_W;
    localparam int OUT_OVER_BIT = OUT_OCC_LSB + CNT_W;
    localparam int OUT_USED_W   = OUT_OVER_BIT + 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic [KIND_W-1:0] KIND_PUSH_TOP  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BOT  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_TOP   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BOT   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_TOP  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BOT  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_READ      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_WRITE     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ROT_DOWN  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ROT_UP    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_FLUSH     = 4'd10;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_POLICY   = 1'b1;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } rem_result_t;

endpackage

// File: rtl/circular_deque_core.sv
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: data_in, position, steps; tuser: kind
// m_axis    out  m_axis_tvalid/tready      tdata: data_out, status, occupancy, overwrote
// apb       in   psel/penable/pready       capacity at 0x0, full_policy at 0x4
//
// push, pop, peek, flush: accept with the memory read, then the execute state with any memory write, then emit
// read/write: 16-step remainder unit, then slot state, plus a data state on read; skipped on an empty store
// rotate: remainder unit (steps mod count), then one read and one write per step (none if count <= 1)
// a result waits in the output register while the next item runs; a finished item
// holds the input until the output register frees
// reset empties the store; element memory is not cleared, no entry is read before written
module circular_deque_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] data_in, [47:32] position, [63:48] steps
    input  logic [cdq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [3:0] kind, [7:4] zero
    input  logic [cdq_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] data_out, [33:32] status, [42:34] occupancy, [43] overwrote, [47:44] zero
    output logic [cdq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cdq_pkg::APB_AW-1:0]         paddr,
    input  logic [cdq_pkg::APB_DW-1:0]         pwdata,
    output logic [cdq_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_SLOT   = 8'b0000_1000,
        S_RDATA  = 8'b0001_0000,
        S_ROT_RD = 8'b0010_0000,
        S_ROT_WR = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    localparam int SW = cdq_pkg::SLOT_W;
    localparam int CW = cdq_pkg::CNT_W;
    localparam int DW = cdq_pkg::DATA_W;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   capacity_reg, capacity_next;
    logic                            policy_reg, policy_next;
    logic [SW-1:0]                   bottom_reg, bottom_next;
    logic [SW-1:0]                   top_reg, top_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [cdq_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [DW-1:0]                   data_reg, data_next;
    logic [cdq_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [cdq_pkg::POS_W-1:0]       steps_reg, steps_next;
    logic [SW-1:0]                   left_reg, left_next;
    logic [DW-1:0]                   res_data_reg, res_data_next;
    logic [cdq_pkg::STAT_W-1:0]      res_stat_reg, res_stat_next;
    logic                            res_over_reg, res_over_next;
    logic                            m_valid_reg, m_valid_next;
    logic [cdq_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [DW-1:0]                   mem_array [cdq_pkg::DEPTH];
    logic [DW-1:0]                   rd_data_reg;
    logic [SW-1:0]                   rd_addr;
    logic                            mem_we;
    logic [SW-1:0]                   mem_wa;
    logic [DW-1:0]                   mem_wd;

    logic                            div_start;
    logic [cdq_pkg::POS_W-1:0]       div_dividend;
    cdq_pkg::rem_result_t            div_res;

    logic [CW-1:0]                   cap_eff;
    logic [SW-1:0]                   cap_last;
    logic                            is_full;
    logic                            out_free;
    logic                            take;
    logic                            cfg_wr;
    logic [CW-1:0]                   slot_sum;
    logic [SW-1:0]                   pos_slot;
    logic [cdq_pkg::KIND_W-1:0]      in_kind;

    function automatic logic [SW-1:0] slot_up(input logic [SW-1:0] s, input logic [SW-1:0] last);
        slot_up = (s == last) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_down(input logic [SW-1:0] s, input logic [SW-1:0] last);
        slot_down = (s == '0) ? last : s - 1'b1;
    endfunction

    cdq_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .result   (div_res)
    );

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (capacity_reg > CW'(cdq_pkg::DEPTH))
        begin
            cap_eff = CW'(cdq_pkg::DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
        cap_last = SW'(cap_eff - 1'b1);
    end

    assign is_full  = (count_reg >= cap_eff);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) || ((state_reg == S_EMIT) && out_free);
    assign take     = s_axis_tvalid && s_axis_tready;
    assign in_kind  = s_axis_tuser[cdq_pkg::KIND_W-1:0];
    assign cfg_wr   = psel && penable && pwrite && pready;

    // bottom plus offset, wrapped once at the capacity
    always_comb
    begin
        slot_sum = CW'(bottom_reg) + CW'(left_reg);
        if (slot_sum >= cap_eff)
        begin
            slot_sum = slot_sum - cap_eff;
        end
        pos_slot = slot_sum[SW-1:0];
    end

    always_comb
    begin
        unique case (state_reg)
            S_SLOT:
            begin
                rd_addr = pos_slot;
            end
            S_ROT_RD:
            begin
                rd_addr = (kind_reg == cdq_pkg::KIND_ROT_DOWN) ? bottom_reg : top_reg;
            end
            default:
            begin
                if ((in_kind == cdq_pkg::KIND_POP_TOP) || (in_kind == cdq_pkg::KIND_PEEK_TOP))
                begin
                    rd_addr = top_reg;
                end
                else
                begin
                    rd_addr = bottom_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        capacity_next = capacity_reg;
        policy_next   = policy_reg;
        bottom_next   = bottom_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        data_next     = data_reg;
        pos_next      = pos_reg;
        steps_next    = steps_reg;
        left_next     = left_reg;
        res_data_next = res_data_reg;
        res_stat_next = res_stat_reg;
        res_over_next = res_over_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = data_reg;
        div_start     = 1'b0;
        div_dividend  = pos_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                res_data_next = '0;
                res_stat_next = cdq_pkg::STAT_OK;
                res_over_next = 1'b0;
                state_next    = S_EMIT;
                case (kind_reg)
                    cdq_pkg::KIND_PUSH_TOP, cdq_pkg::KIND_PUSH_BOT:
                    begin
                        if (count_reg == '0)
                        begin
                            bottom_next = '0;
                            top_next    = '0;
                            count_next  = CW'(1);
                            mem_we      = 1'b1;
                            mem_wa      = '0;
                        end
                        else if (is_full && policy_reg)
                        begin
                            res_stat_next = cdq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            if (is_full)
                            begin
                                res_over_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            mem_we = 1'b1;
                            if (kind_reg == cdq_pkg::KIND_PUSH_TOP)
                            begin
                                if (is_full)
                                begin
                                    bottom_next = slot_up(bottom_reg, cap_last);
                                end
                                top_next = slot_up(top_reg, cap_last);
                                mem_wa   = top_next;
                            end
                            else
                            begin
                                if (is_full)
                                begin
                                    top_next = slot_down(top_reg, cap_last);
                                end
                                bottom_next = slot_down(bottom_reg, cap_last);
                                mem_wa      = bottom_next;
                            end
                        end
                    end
                    cdq_pkg::KIND_POP_TOP, cdq_pkg::KIND_POP_BOT,
                    cdq_pkg::KIND_PEEK_TOP, cdq_pkg::KIND_PEEK_BOT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_stat_next = cdq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            res_data_next = rd_data_reg;
                            if (kind_reg == cdq_pkg::KIND_POP_TOP)
                            begin
                                top_next = slot_down(top_reg, cap_last);
                            end
                            if (kind_reg == cdq_pkg::KIND_POP_BOT)
                            begin
                                bottom_next = slot_up(bottom_reg, cap_last);
                            end
                            if ((kind_reg == cdq_pkg::KIND_POP_TOP) ||
                                (kind_reg == cdq_pkg::KIND_POP_BOT))
                            begin
                                count_next = count_reg - 1'b1;
                                if (count_reg == CW'(1))
                                begin
                                    bottom_next = '0;
                                    top_next    = '0;
                                end
                            end
                        end
                    end
                    cdq_pkg::KIND_READ, cdq_pkg::KIND_WRITE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_stat_next = cdq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = pos_reg;
                            state_next   = S_DIV;
                        end
                    end
                    cdq_pkg::KIND_ROT_DOWN, cdq_pkg::KIND_ROT_UP:
                    begin
                        if (count_reg > CW'(1))
                        begin
                            div_start    = 1'b1;
                            div_dividend = steps_reg;
                            state_next   = S_DIV;
                        end
                    end
                    cdq_pkg::KIND_FLUSH:
                    begin
                        count_next  = '0;
                        bottom_next = '0;
                        top_next    = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    left_next = div_res.rem;
                    if ((kind_reg == cdq_pkg::KIND_READ) || (kind_reg == cdq_pkg::KIND_WRITE))
                    begin
                        state_next = S_SLOT;
                    end
                    else if (div_res.rem == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_ROT_RD;
                    end
                end
            end
            S_SLOT:
            begin
                if (kind_reg == cdq_pkg::KIND_WRITE)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = pos_slot;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RDATA;
                end
            end
            S_RDATA:
            begin
                res_data_next = rd_data_reg;
                state_next    = S_EMIT;
            end
            S_ROT_RD:
            begin
                left_next  = left_reg - 1'b1;
                state_next = S_ROT_WR;
            end
            S_ROT_WR:
            begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg;
                if (kind_reg == cdq_pkg::KIND_ROT_DOWN)
                begin
                    bottom_next = slot_up(bottom_reg, cap_last);
                    top_next    = slot_up(top_reg, cap_last);
                    mem_wa      = top_next;
                end
                else
                begin
                    top_next    = slot_down(top_reg, cap_last);
                    bottom_next = slot_down(bottom_reg, cap_last);
                    mem_wa      = bottom_next;
                end
                state_next = (left_reg == '0) ? S_EMIT : S_ROT_RD;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = cdq_pkg::OUT_TDATA_W'({res_over_reg, count_reg,
                                                          res_stat_reg, res_data_reg});
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (take)
        begin
            kind_next  = in_kind;
            data_next  = s_axis_tdata[DW-1:0];
            pos_next   = s_axis_tdata[DW+cdq_pkg::POS_W-1:DW];
            steps_next = s_axis_tdata[DW+2*cdq_pkg::POS_W-1:DW+cdq_pkg::POS_W];
            state_next = S_EXEC;
        end

        if (cfg_wr)
        begin
            if (paddr[2] == cdq_pkg::REG_CAPACITY)
            begin
                capacity_next = pwdata[CW-1:0];
                count_next    = '0;
                bottom_next   = '0;
                top_next      = '0;
            end
            else
            begin
                policy_next = pwdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            capacity_reg <= cdq_pkg::CAP_RESET;
            policy_reg   <= 1'b0;
            bottom_reg   <= '0;
            top_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            policy_reg   <= policy_next;
            bottom_reg   <= bottom_next;
            top_reg      <= top_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        data_reg     <= data_next;
        pos_reg      <= pos_next;
        steps_reg    <= steps_next;
        left_reg     <= left_next;
        res_data_reg <= res_data_next;
        res_stat_reg <= res_stat_next;
        res_over_reg <= res_over_next;
        m_data_reg   <= m_data_next;
    end

    // element store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    always_comb
    begin
        if (paddr[2] == cdq_pkg::REG_CAPACITY)
        begin
            prdata = cdq_pkg::APB_DW'(capacity_reg);
        end
        else
        begin
            prdata = cdq_pkg::APB_DW'(policy_reg);
        end
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: rtl/cdq_rem_unit.sv
module cdq_rem_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cdq_pkg::POS_W-1:0]   dividend,
    input  logic [cdq_pkg::CNT_W-1:0]   divisor,
    output cdq_pkg::rem_result_t        result
);

    logic                                busy_reg;
    logic [cdq_pkg::STEP_CNT_W-1:0]      cnt_reg;
    logic [cdq_pkg::POS_W-1:0]           quo_reg;
    logic [cdq_pkg::SLOT_W-1:0]          rem_reg;
    logic [cdq_pkg::SH_W-1:0]            divisor_reg;
    logic [cdq_pkg::SH_W-1:0]            shifted;
    logic [cdq_pkg::SH_W-1:0]            rem_next;

    // one quotient bit per cycle, msb first
    always_comb
    begin
        shifted = {rem_reg, quo_reg[cdq_pkg::POS_W-1]};
        if (shifted >= divisor_reg)
        begin
            rem_next = shifted - divisor_reg;
        end
        else
        begin
            rem_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cdq_pkg::STEP_CNT_W'(cdq_pkg::POS_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= cdq_pkg::SH_W'(divisor);
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[cdq_pkg::POS_W-2:0], 1'b0};
            rem_reg <= rem_next[cdq_pkg::SLOT_W-1:0];
        end
    end

    assign result.done = busy_reg && (cnt_reg == '0);
    assign result.rem  = rem_next[cdq_pkg::SLOT_W-1:0];

endmodule

// File: rtl/cdq_checker.sv
module cdq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int SL = cdq_pkg::OUT_STAT_LSB;
    localparam int OL = cdq_pkg::OUT_OCC_LSB;
    localparam int OB = cdq_pkg::OUT_OVER_BIT;

    // stalled item stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OB-1:OL] <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
        else $error("occupancy above depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OL-1:SL] == cdq_pkg::STAT_OK) ||
                          (m_axis_tdata[OL-1:SL] == cdq_pkg::STAT_EMPTY) ||
                          (m_axis_tdata[OL-1:SL] == cdq_pkg::STAT_FULL))
        else $error("undefined status code");

    // overwrite only on a successful push into a full store
    a_over_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OB] |->
            (m_axis_tdata[OL-1:SL] == cdq_pkg::STAT_OK) &&
            (m_axis_tdata[SL-1:0] == '0) && (m_axis_tdata[OB-1:OL] != '0))
        else $error("overwrite flag on a non-push result");

    // errors leave no data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[OL-1:SL] != cdq_pkg::STAT_OK) |->
            (m_axis_tdata[SL-1:0] == '0) && !m_axis_tdata[OB])
        else $error("error result carries data");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/circular_deque_core_tb.sv
`timescale 1ns / 1ps

module circular_deque_core_tb;

    import cdq_pkg::*;

    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 600;
    localparam int PRINT_MAX    = 40;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd11;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

    localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_POLICY   = {REG_POLICY, 2'b00};

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  steps;
        bit                gate;
    } deque_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occupancy;
        logic              overwrote;
    } deque_res_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] data_in, [47:32] position, [63:48] steps
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [3:0] kind, [7:4] zero
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] data_out, [33:32] status, [42:34] occupancy, [43] overwrote, [47:44] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // predictor state
    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [SLOT_W-1:0] bot_slot = '0;
    logic [SLOT_W-1:0] top_slot = '0;
    logic [CNT_W-1:0]  fill = '0;
    logic [CNT_W-1:0]  cap_reg = CAP_RESET;
    logic              policy_reg = 1'b0;

    deque_cmd_t pending_q[$];
    deque_res_t expect_q[$];
    deque_cmd_t cur_cmd;

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    event rx_hold_start;

    int err_count = 0;
    int n_cmds = 0;
    int n_results = 0;
    int n_over = 0;
    int n_reject = 0;
    int n_empty = 0;
    int n_settings = 0;
    int cycles = 0;

    circular_deque_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [SLOT_W-1:0] wrap_up(input logic [SLOT_W-1:0] s, input int cap);
        return SLOT_W'((int'(s) + 1) % cap);
    endfunction

    function automatic logic [SLOT_W-1:0] wrap_down(input logic [SLOT_W-1:0] s, input int cap);
        return (s == 0) ? SLOT_W'(cap - 1) : s - 1'b1;
    endfunction

    function automatic void deque_clear();
        fill = '0;
        bot_slot = '0;
        top_slot = '0;
    endfunction

    function automatic deque_res_t deque_apply(input deque_cmd_t c);
        deque_res_t r;
        int cap;
        logic [SLOT_W-1:0] slot;
        int n;
        logic [DATA_W-1:0] moved;
        cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        r.value = '0;
        r.status = STAT_OK;
        r.overwrote = 1'b0;
        case (c.kind)
            KIND_PUSH_TOP, KIND_PUSH_BOT:
            begin
                if (fill == 0)
                begin
                    deque_clear();
                    fill = CNT_W'(1);
                    store_mem[0] = c.value;
                end
                else if (int'(fill) >= cap && policy_reg)
                begin
                    r.status = STAT_FULL;
                    n_reject++;
                end
                else
                begin
                    if (int'(fill) >= cap)
                    begin
                        // full store: the opposite end gets dropped
                        r.overwrote = 1'b1;
                        n_over++;
                        if (c.kind == KIND_PUSH_TOP)
                            bot_slot = wrap_up(bot_slot, cap);
                        else
                            top_slot = wrap_down(top_slot, cap);
                    end
                    else
                        fill = fill + 1'b1;
                    if (c.kind == KIND_PUSH_TOP)
                    begin
                        top_slot = wrap_up(top_slot, cap);
                        store_mem[top_slot] = c.value;
                    end
                    else
                    begin
                        bot_slot = wrap_down(bot_slot, cap);
                        store_mem[bot_slot] = c.value;
                    end
                end
            end
            KIND_POP_TOP, KIND_POP_BOT, KIND_PEEK_TOP, KIND_PEEK_BOT, KIND_READ, KIND_WRITE:
            begin
                if (fill == 0)
                begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    if (c.kind == KIND_POP_TOP || c.kind == KIND_PEEK_TOP)
                        slot = top_slot;
                    else if (c.kind == KIND_POP_BOT || c.kind == KIND_PEEK_BOT)
                        slot = bot_slot;
                    else
                        slot = SLOT_W'((int'(bot_slot) + int'(c.pos) % int'(fill)) % cap);
                    if (c.kind == KIND_WRITE)
                        store_mem[slot] = c.value;
                    else
                    begin
                        r.value = store_mem[slot];
                        if (c.kind == KIND_POP_TOP || c.kind == KIND_POP_BOT)
                        begin
                            if (c.kind == KIND_POP_TOP)
                                top_slot = wrap_down(top_slot, cap);
                            else
                                bot_slot = wrap_up(bot_slot, cap);
                            fill = fill - 1'b1;
                            if (fill == 0)
                                deque_clear();
                        end
                    end
                end
            end
            KIND_ROT_DOWN, KIND_ROT_UP:
            begin
                if (fill > 1)
                begin
                    n = int'(c.steps) % int'(fill);
                    for (int k = 0; k < n; k++)
                    begin
                        if (c.kind == KIND_ROT_DOWN)
                        begin
                            moved = store_mem[bot_slot];
                            bot_slot = wrap_up(bot_slot, cap);
                            top_slot = wrap_up(top_slot, cap);
                            store_mem[top_slot] = moved;
                        end
                        else
                        begin
                            moved = store_mem[top_slot];
                            top_slot = wrap_down(top_slot, cap);
                            bot_slot = wrap_down(bot_slot, cap);
                            store_mem[bot_slot] = moved;
                        end
                    end
                end
            end
            KIND_FLUSH:
                deque_clear();
            default:
                ;
        endcase
        r.occupancy = fill;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    // driver: one item at a time from the pending queue, held until taken
    always @(posedge clk or negedge rst_n)
    begin : drv
        deque_res_t want;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = deque_apply(cur_cmd);
                expect_q.push_back(want);
                n_cmds++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct
                    && !(pending_q[0].gate && expect_q.size() != 0))
                begin
                    cur_cmd = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_cmd.steps, cur_cmd.pos, cur_cmd.value};
                    s_axis_tuser <= {{(IN_TUSER_W - KIND_W){1'b0}}, cur_cmd.kind};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // long receiver hold-off
    always
    begin
        @(rx_hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: sampled mid-cycle, the pair seen here is taken at the next rising edge
    always @(negedge clk)
    begin : mon
        deque_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expect_q.size() == 0)
                report_mismatch("unexpected result", 64'(m_axis_tdata), '0);
            else
            begin
                want = expect_q.pop_front();
                n_results++;
                if (m_axis_tdata[OUT_DATA_LSB +: DATA_W] !== want.value)
                    report_mismatch("data_out", 64'(m_axis_tdata[OUT_DATA_LSB +: DATA_W]),
                                    64'(want.value));
                if (m_axis_tdata[OUT_STAT_LSB +: STAT_W] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[OUT_STAT_LSB +: STAT_W]),
                                    64'(want.status));
                if (m_axis_tdata[OUT_OCC_LSB +: CNT_W] !== want.occupancy)
                    report_mismatch("occupancy", 64'(m_axis_tdata[OUT_OCC_LSB +: CNT_W]),
                                    64'(want.occupancy));
                if (m_axis_tdata[OUT_OVER_BIT] !== want.overwrote)
                    report_mismatch("overwrote", 64'(m_axis_tdata[OUT_OVER_BIT]),
                                    64'(want.overwrote));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                             input logic [POS_W-1:0] pos, input logic [POS_W-1:0] steps);
        deque_cmd_t c;
        c.kind = kind;
        c.value = value;
        c.pos = pos;
        c.steps = steps;
        c.gate = 1'b0;
        pending_q.push_back(c);
    endtask

    function automatic logic [POS_W-1:0] rand_index();
        case ($urandom_range(0, 2))
            0: return POS_W'($urandom_range(0, 7));
            1: return POS_W'($urandom_range(0, 300));
            default: return POS_W'($urandom());
        endcase
    endfunction

    task automatic queue_random(input int n, input int push_pct, input int flush_pct,
                                input int gate_at);
        deque_cmd_t c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                c.kind = r[0] ? KIND_PUSH_TOP : KIND_PUSH_BOT;
            else if (r < push_pct + flush_pct)
                c.kind = KIND_FLUSH;
            else if (r < push_pct + flush_pct + 3)
                c.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else
                c.kind = KIND_W'($urandom_range(KIND_POP_TOP, KIND_ROT_UP));
            r = $urandom_range(0, 99);
            c.value = (r < 5) ? '0 : (r < 10) ? '1 : DATA_W'($urandom());
            c.pos = rand_index();
            c.steps = rand_index();
            c.gate = (i == gate_at);
            pending_q.push_back(c);
        end
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_CAPACITY)
        begin
            cap_reg = value[CNT_W-1:0];
            deque_clear();
        end
        else if (addr == ADDR_POLICY)
            policy_reg = value[0];
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int cap, input int pol, input int tx_pct, input int rx_pct,
                             input int n, input int push_pct, input int flush_pct,
                             input bit hold, input int gate_at);
        wait_drained();
        apb_write(ADDR_CAPACITY, APB_DW'(cap));
        apb_write(ADDR_POLICY, APB_DW'(pol));
        n_settings++;
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        queue_random(n, push_pct, flush_pct, gate_at);
        if (hold)
            -> rx_hold_start;
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, single element, end and position accesses, rotations, unused kinds
        queue_cmd(KIND_POP_TOP,   32'h0000_0001, 16'h0000, 16'h0000);
        queue_cmd(KIND_PEEK_BOT,  32'h0000_0002, 16'h0000, 16'h0000);
        queue_cmd(KIND_READ,      32'h0000_0003, 16'hFFFF, 16'h0000);
        queue_cmd(KIND_WRITE,     32'hFFFF_FFFF, 16'h0001, 16'h0000);
        queue_cmd(KIND_ROT_DOWN,  32'h0000_0000, 16'h0000, 16'h0003);
        queue_cmd(KIND_PUSH_TOP,  32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_ROT_UP,    32'h0000_0000, 16'h0000, 16'hFFFF);
        queue_cmd(KIND_PUSH_TOP,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(KIND_PUSH_BOT,  32'h5A5A_A5A5, 16'h0000, 16'h0000);
        queue_cmd(KIND_PEEK_TOP,  32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_PEEK_BOT,  32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_READ,      32'h0000_0000, 16'hFFFF, 16'h0000);
        queue_cmd(KIND_WRITE,     32'h1234_5678, 16'h8000, 16'h0000);
        queue_cmd(KIND_READ,      32'h0000_0000, 16'h0001, 16'h0000);
        queue_cmd(KIND_ROT_DOWN,  32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_ROT_DOWN,  32'h0000_0000, 16'h0000, 16'hFFFF);
        queue_cmd(KIND_ROT_UP,    32'h0000_0000, 16'h0000, 16'h0002);
        queue_cmd(KIND_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(KIND_UNUSED_HI, 32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_POP_TOP,   32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_POP_BOT,   32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_POP_TOP,   32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_PUSH_BOT,  32'h8000_0001, 16'h0000, 16'h0000);
        queue_cmd(KIND_FLUSH,     32'h0000_0000, 16'h0000, 16'h0000);
        queue_cmd(KIND_POP_BOT,   32'h0000_0000, 16'h0000, 16'h0000);
        n_settings++;

        //        cap  pol  tx  rx    n  push flush hold gate
        run_phase(256,  0,   0,  0, 420,  70,  0,   0,   -1);
        run_phase(1,    1,  75,  0, 100,  45,  2,   0,   -1);
        run_phase(0,    0,   0, 75,  80,  45,  2,   0,   -1);
        run_phase(5,    1,   8,  8, 180,  45,  2,   1,   90);
        run_phase(2,    0,   0,  0,  80,  40,  2,   0,   -1);
        run_phase(511,  1,   8,  8, 140,  50,  1,   0,   -1);
        run_phase(17,   0,   0, 75, 100,  45,  2,   0,   -1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands under %0d capacity/policy settings, %0d results checked",
                 n_cmds, n_settings, n_results);
        $display("%0d overwrites at a full store, %0d rejected pushes, %0d empty-store errors",
                 n_over, n_reject, n_empty);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
